@@ src/hcr_pkg.sv @@
// Shared types, constants and helpers of the Harris corner response block.
package hcr_pkg;

  // Frame limits and field widths
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int PIX_W      = 8;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 10;
  localparam int DIM_W      = 11;
  localparam int K_W        = 15;
  localparam int RESP_W     = 48;
  localparam int LAG_W      = 12;

  // Line store: eight row slots of one maximum-width row each
  localparam int SLOT_W     = 3;
  localparam int ADDR_W     = SLOT_W + COL_W;
  localparam int MEM_DEPTH  = 1 << ADDR_W;

  // 5x5 pixel window feeding a 3x3 sum of Sobel products
  localparam int WIN_DIM    = 5;
  localparam int WIN_N      = WIN_DIM * WIN_DIM;
  localparam int GRAD_N     = 9;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 15;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_K_COEFF      = 2'd2;

  localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 11'd752;
  localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 11'd480;
  localparam logic [K_W-1:0]   RST_K_COEFF      = 15'd2621;

  // Item kinds
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [PIX_W-1:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic signed [RESP_W-1:0] response;
    logic [COL_W-1:0]         col;
    logic [ROW_W-1:0]         row;
    logic                     frame_last;
  } out_item_t;

  typedef logic [WIN_N-1:0][PIX_W-1:0] pix_win_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_DONE
  } ctl_state_t;

  typedef enum logic [3:0] {
    MS_IDLE,
    MS_GRAD,
    MS_MAC,
    MS_MUL1,
    MS_MUL2,
    MS_MUL3,
    MS_MUL4,
    MS_MUL5,
    MS_KT,
    MS_RESP,
    MS_DONE
  } math_state_t;

  // Zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ src/harris_corner_response.sv @@
// Top level: raster bookkeeping, pixel line store and result register.
//
//  Channel  Ports                            Moves
//  input    in_valid/in_ready/in_data        pixel or flush item
//  output   out_valid/out_ready/out_data     response with column, row, frame end
//  config   cfg_we/cfg_addr/cfg_wdata        register write, no wait
//
// A pixel item that yields no result is accepted without leaving the idle state.
// An item that yields a result, when the output register is free, passes through
// the accept, the reads from the line store that gather the 5x5 window, the
// shared multiply sequencer and the load of the output register.
// Reset is synchronous; the line store is not cleared. A finished result
// sits in the output register while the next item is accepted; a full
// output register holds the controller in its done state until it drains.
module harris_corner_response (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  hcr_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output hcr_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [hcr_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [hcr_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  hcr_pkg::ctl_state_t state_r, state_nxt;

  // Configuration and per-frame latched settings
  logic [hcr_pkg::DIM_W-1:0] cfg_w_r, cfg_h_r;
  logic [hcr_pkg::K_W-1:0]   cfg_k_r;
  logic [hcr_pkg::DIM_W-1:0] act_w_r, act_h_r, act_w_nxt, act_h_nxt;
  logic [hcr_pkg::K_W-1:0]   act_k_r, act_k_nxt;

  // Raster counters
  logic [hcr_pkg::COL_W-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [hcr_pkg::ROW_W-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [hcr_pkg::LAG_W-1:0] lag_r, lag_nxt;
  logic                      pending_r, pending_nxt, active_r, active_nxt;

  // Job under work
  logic [hcr_pkg::COL_W-1:0] job_col_r, job_col_nxt;
  logic [hcr_pkg::ROW_W-1:0] job_row_r, job_row_nxt;
  logic                      job_last_r, job_last_nxt;
  logic                      go_job;

  // Window gather
  logic [4:0] rd_idx_r, rd_idx_nxt;
  logic [2:0] dr_r, dr_nxt, dc_r, dc_nxt;
  hcr_pkg::pix_win_t win_r;

  // Line store
  logic [hcr_pkg::PIX_W-1:0]  mem [hcr_pkg::MEM_DEPTH];
  logic [hcr_pkg::PIX_W-1:0]  rd_data_r;
  logic [hcr_pkg::ADDR_W-1:0] waddr, raddr;
  logic                       mem_we;

  // Output register and strobes
  hcr_pkg::out_item_t out_data_r;
  logic               out_valid_r;
  logic               accept, math_start, math_done, out_load;
  logic signed [hcr_pkg::RESP_W-1:0] math_resp;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hcr_pkg::ST_IDLE: if (accept && go_job) state_nxt = hcr_pkg::ST_READ;
      hcr_pkg::ST_READ: if (rd_idx_r == 5'(hcr_pkg::WIN_N)) state_nxt = hcr_pkg::ST_CALC;
      hcr_pkg::ST_CALC: if (math_done) state_nxt = hcr_pkg::ST_DONE;
      hcr_pkg::ST_DONE: if (out_load) state_nxt = hcr_pkg::ST_IDLE;
      default:          state_nxt = hcr_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the controller
  always_comb begin
    in_ready   = (state_r == hcr_pkg::ST_IDLE);
    math_start = (state_r == hcr_pkg::ST_READ) && (rd_idx_r == 5'(hcr_pkg::WIN_N));
    out_load   = (state_r == hcr_pkg::ST_DONE) && (!out_valid_r || out_ready);
  end

  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Raster bookkeeping for an accepted item
  always_comb begin
    logic                      start;
    logic [hcr_pkg::DIM_W-1:0] eff_w, eff_h, oc1, ic1, ir1, or1;
    logic [hcr_pkg::COL_W-1:0] eff_ic, eff_oc;
    logic [hcr_pkg::ROW_W-1:0] eff_ir, eff_or;
    logic [hcr_pkg::LAG_W-1:0] eff_lag;

    act_w_nxt    = act_w_r;
    act_h_nxt    = act_h_r;
    act_k_nxt    = act_k_r;
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    lag_nxt      = lag_r;
    pending_nxt  = pending_r;
    active_nxt   = active_r;
    job_col_nxt  = job_col_r;
    job_row_nxt  = job_row_r;
    job_last_nxt = job_last_r;
    go_job       = 1'b0;
    mem_we       = 1'b0;

    start = (in_data.mode == hcr_pkg::MODE_PIXEL) && (!active_r || pending_r);
    if (start) begin
      eff_w   = hcr_pkg::clamp_dim(cfg_w_r, hcr_pkg::DIM_W'(hcr_pkg::MAX_WIDTH));
      eff_h   = hcr_pkg::clamp_dim(cfg_h_r, hcr_pkg::DIM_W'(hcr_pkg::MAX_HEIGHT));
      eff_ic  = '0;
      eff_ir  = '0;
      eff_oc  = '0;
      eff_or  = '0;
      eff_lag = {eff_w, 1'b0} + hcr_pkg::LAG_W'(2);
    end else begin
      eff_w   = act_w_r;
      eff_h   = act_h_r;
      eff_ic  = in_col_r;
      eff_ir  = in_row_r;
      eff_oc  = out_col_r;
      eff_or  = out_row_r;
      eff_lag = lag_r;
    end
    oc1 = {1'b0, eff_oc} + hcr_pkg::DIM_W'(1);
    or1 = {1'b0, eff_or} + hcr_pkg::DIM_W'(1);
    ic1 = {1'b0, eff_ic} + hcr_pkg::DIM_W'(1);
    ir1 = {1'b0, eff_ir} + hcr_pkg::DIM_W'(1);

    if (accept) begin
      if (in_data.mode == hcr_pkg::MODE_PIXEL) begin
        mem_we      = 1'b1;
        act_w_nxt   = eff_w;
        act_h_nxt   = eff_h;
        if (start) act_k_nxt = cfg_k_r;
        active_nxt  = 1'b1;
        pending_nxt = 1'b0;
        out_col_nxt = eff_oc;
        out_row_nxt = eff_or;
        // result lags the input by two rows and two pixels
        if (eff_lag == '0) begin
          go_job       = 1'b1;
          job_col_nxt  = eff_oc;
          job_row_nxt  = eff_or;
          job_last_nxt = 1'b0;
          if (oc1 >= eff_w) begin
            out_col_nxt = '0;
            out_row_nxt = or1[hcr_pkg::ROW_W-1:0];
          end else begin
            out_col_nxt = oc1[hcr_pkg::COL_W-1:0];
          end
          lag_nxt = '0;
        end else begin
          lag_nxt = eff_lag - hcr_pkg::LAG_W'(1);
        end
        // advance the input position, frame end arms the drain
        if (ic1 >= eff_w) begin
          in_col_nxt = '0;
          if (ir1 >= eff_h) begin
            in_row_nxt  = '0;
            pending_nxt = 1'b1;
          end else begin
            in_row_nxt = ir1[hcr_pkg::ROW_W-1:0];
          end
        end else begin
          in_col_nxt = ic1[hcr_pkg::COL_W-1:0];
          in_row_nxt = eff_ir;
        end
      end else if (pending_r) begin
        // flush: emit the next owed result
        go_job       = 1'b1;
        job_col_nxt  = out_col_r;
        job_row_nxt  = out_row_r;
        job_last_nxt = 1'b0;
        if (oc1 >= act_w_r) begin
          out_col_nxt = '0;
          out_row_nxt = or1[hcr_pkg::ROW_W-1:0];
          if (or1 >= act_h_r) begin
            job_last_nxt = 1'b1;
            pending_nxt  = 1'b0;
            active_nxt   = 1'b0;
            in_col_nxt   = '0;
            in_row_nxt   = '0;
            out_row_nxt  = '0;
          end
        end else begin
          out_col_nxt = oc1[hcr_pkg::COL_W-1:0];
        end
      end
    end
  end

  // Window read sequencing
  always_comb begin
    rd_idx_nxt = rd_idx_r;
    dr_nxt     = dr_r;
    dc_nxt     = dc_r;
    if (state_r == hcr_pkg::ST_IDLE) begin
      rd_idx_nxt = '0;
      dr_nxt     = '0;
      dc_nxt     = '0;
    end else if (state_r == hcr_pkg::ST_READ) begin
      rd_idx_nxt = rd_idx_r + 5'd1;
      if (dc_r == 3'(hcr_pkg::WIN_DIM - 1)) begin
        dc_nxt = '0;
        dr_nxt = dr_r + 3'd1;
      end else begin
        dc_nxt = dc_r + 3'd1;
      end
    end
  end

  // Clamped window coordinates into the line store
  always_comb begin
    logic signed [11:0]        rs, cs;
    logic [hcr_pkg::ROW_W-1:0] rrow;
    logic [hcr_pkg::COL_W-1:0] rcol;
    rs = $signed({2'b00, job_row_r}) + $signed({9'b0, dr_r}) - 12'sd2;
    cs = $signed({2'b00, job_col_r}) + $signed({9'b0, dc_r}) - 12'sd2;
    if (rs < 12'sd0) begin
      rrow = '0;
    end else if (rs > $signed({1'b0, act_h_r}) - 12'sd1) begin
      rrow = hcr_pkg::ROW_W'(act_h_r - hcr_pkg::DIM_W'(1));
    end else begin
      rrow = rs[hcr_pkg::ROW_W-1:0];
    end
    if (cs < 12'sd0) begin
      rcol = '0;
    end else if (cs > $signed({1'b0, act_w_r}) - 12'sd1) begin
      rcol = hcr_pkg::COL_W'(act_w_r - hcr_pkg::DIM_W'(1));
    end else begin
      rcol = cs[hcr_pkg::COL_W-1:0];
    end
    raddr = {rrow[hcr_pkg::SLOT_W-1:0], rcol};
  end

  // Row slot is the low row bits; write position uses the effective counters
  assign waddr = {(in_data.mode == hcr_pkg::MODE_PIXEL && (!active_r || pending_r))
                  ? {hcr_pkg::SLOT_W{1'b0}} : in_row_r[hcr_pkg::SLOT_W-1:0],
                  (in_data.mode == hcr_pkg::MODE_PIXEL && (!active_r || pending_r))
                  ? {hcr_pkg::COL_W{1'b0}} : in_col_r};

  // Line store memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= in_data.pixel;
    end
    rd_data_r <= mem[raddr];
  end

  // Window shift: first read ends at entry 0
  always_ff @(posedge clk) begin
    if (state_r == hcr_pkg::ST_READ && rd_idx_r != '0) begin
      win_r <= {rd_data_r, win_r[hcr_pkg::WIN_N-1:1]};
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hcr_pkg::ST_IDLE;
      cfg_w_r     <= hcr_pkg::RST_FRAME_WIDTH;
      cfg_h_r     <= hcr_pkg::RST_FRAME_HEIGHT;
      cfg_k_r     <= hcr_pkg::RST_K_COEFF;
      act_w_r     <= hcr_pkg::RST_FRAME_WIDTH;
      act_h_r     <= hcr_pkg::RST_FRAME_HEIGHT;
      act_k_r     <= hcr_pkg::RST_K_COEFF;
      in_col_r    <= '0;
      in_row_r    <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      lag_r       <= '0;
      pending_r   <= 1'b0;
      active_r    <= 1'b0;
      rd_idx_r    <= '0;
      dr_r        <= '0;
      dc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      act_w_r   <= act_w_nxt;
      act_h_r   <= act_h_nxt;
      act_k_r   <= act_k_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      lag_r     <= lag_nxt;
      pending_r <= pending_nxt;
      active_r  <= active_nxt;
      rd_idx_r  <= rd_idx_nxt;
      dr_r      <= dr_nxt;
      dc_r      <= dc_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          hcr_pkg::REG_FRAME_WIDTH:  cfg_w_r <= cfg_wdata[hcr_pkg::DIM_W-1:0];
          hcr_pkg::REG_FRAME_HEIGHT: cfg_h_r <= cfg_wdata[hcr_pkg::DIM_W-1:0];
          hcr_pkg::REG_K_COEFF:      cfg_k_r <= cfg_wdata[hcr_pkg::K_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Job and result payload
  always_ff @(posedge clk) begin
    job_col_r  <= job_col_nxt;
    job_row_r  <= job_row_nxt;
    job_last_r <= job_last_nxt;
    if (out_load) begin
      out_data_r.response   <= math_resp;
      out_data_r.col        <= job_col_r;
      out_data_r.row        <= job_row_r;
      out_data_r.frame_last <= job_last_r;
    end
  end

  hcr_math u_math (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (math_start),
    .win      (win_r),
    .k_coeff  (act_k_r),
    .done     (math_done),
    .response (math_resp)
  );

endmodule

@@ src/hcr_math.sv @@
// Response arithmetic: Sobel gradients, 3x3 sums and det - k*trace^2.
module hcr_math (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  hcr_pkg::pix_win_t             win,
  input  logic [hcr_pkg::K_W-1:0]       k_coeff,
  output logic                          done,
  output logic signed [hcr_pkg::RESP_W-1:0] response
);

  hcr_pkg::math_state_t state_r, state_nxt;

  logic [3:0]          mac_cnt_r;
  logic signed [10:0]  gx_r [hcr_pkg::GRAD_N];
  logic signed [10:0]  gy_r [hcr_pkg::GRAD_N];
  logic signed [10:0]  gx_c [hcr_pkg::GRAD_N];
  logic signed [10:0]  gy_c [hcr_pkg::GRAD_N];
  logic [23:0]         sxx_r, syy_r;
  logic signed [24:0]  sxy_r;
  logic [47:0]         p1_r, p2_r;
  logic [24:0]         tr_r;
  logic [49:0]         tr2_r;
  logic signed [48:0]  det_r;
  logic [46:0]         klo_r;
  logic [32:0]         khi_r;
  logic [48:0]         kt_r;
  logic signed [hcr_pkg::RESP_W-1:0] resp_r;

  logic signed [21:0]  pxx, pyy, pxy;
  logic signed [49:0]  sxy_sq;
  logic [64:0]         ksum;
  logic signed [50:0]  resp_wide;
  logic signed [hcr_pkg::RESP_W-1:0] resp_sat;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hcr_pkg::MS_IDLE: if (start) state_nxt = hcr_pkg::MS_GRAD;
      hcr_pkg::MS_GRAD: state_nxt = hcr_pkg::MS_MAC;
      hcr_pkg::MS_MAC:  if (mac_cnt_r == 4'(hcr_pkg::GRAD_N - 1)) state_nxt = hcr_pkg::MS_MUL1;
      hcr_pkg::MS_MUL1: state_nxt = hcr_pkg::MS_MUL2;
      hcr_pkg::MS_MUL2: state_nxt = hcr_pkg::MS_MUL3;
      hcr_pkg::MS_MUL3: state_nxt = hcr_pkg::MS_MUL4;
      hcr_pkg::MS_MUL4: state_nxt = hcr_pkg::MS_MUL5;
      hcr_pkg::MS_MUL5: state_nxt = hcr_pkg::MS_KT;
      hcr_pkg::MS_KT:   state_nxt = hcr_pkg::MS_RESP;
      hcr_pkg::MS_RESP: state_nxt = hcr_pkg::MS_DONE;
      hcr_pkg::MS_DONE: state_nxt = hcr_pkg::MS_IDLE;
      default:          state_nxt = hcr_pkg::MS_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    done     = (state_r == hcr_pkg::MS_DONE);
    response = resp_r;
  end

  // Gradients at the nine inner window positions
  always_comb begin
    logic [9:0] pos_a, neg_a, pos_b, neg_b;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pos_a = 10'(win[(i)*5 + j + 2]) + {1'b0, win[(i+1)*5 + j + 2], 1'b0}
              + 10'(win[(i+2)*5 + j + 2]);
        neg_a = 10'(win[(i)*5 + j]) + {1'b0, win[(i+1)*5 + j], 1'b0}
              + 10'(win[(i+2)*5 + j]);
        pos_b = 10'(win[(i+2)*5 + j]) + {1'b0, win[(i+2)*5 + j + 1], 1'b0}
              + 10'(win[(i+2)*5 + j + 2]);
        neg_b = 10'(win[(i)*5 + j]) + {1'b0, win[(i)*5 + j + 1], 1'b0}
              + 10'(win[(i)*5 + j + 2]);
        gx_c[i*3 + j] = $signed({1'b0, pos_a}) - $signed({1'b0, neg_a});
        gy_c[i*3 + j] = $signed({1'b0, pos_b}) - $signed({1'b0, neg_b});
      end
    end
  end

  // Products, final sum and saturation
  always_comb begin
    pxx    = gx_r[0] * gx_r[0];
    pyy    = gy_r[0] * gy_r[0];
    pxy    = gx_r[0] * gy_r[0];
    sxy_sq = sxy_r * sxy_r;
    ksum   = {khi_r, 32'b0} + 65'(klo_r);
    resp_wide = 51'(det_r) - $signed({2'b00, kt_r});
    if (resp_wide[50:47] == 4'b0000 || resp_wide[50:47] == 4'b1111) begin
      resp_sat = resp_wide[47:0];
    end else if (resp_wide[50]) begin
      resp_sat = {1'b1, {(hcr_pkg::RESP_W-1){1'b0}}};
    end else begin
      resp_sat = {1'b0, {(hcr_pkg::RESP_W-1){1'b1}}};
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= hcr_pkg::MS_IDLE;
      mac_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == hcr_pkg::MS_MAC) begin
        mac_cnt_r <= mac_cnt_r + 4'd1;
      end else begin
        mac_cnt_r <= '0;
      end
    end
  end

  // Datapath: the step that each working state performs
  always_ff @(posedge clk) begin
    case (state_r)
      hcr_pkg::MS_GRAD: begin
        gx_r  <= gx_c;
        gy_r  <= gy_c;
        sxx_r <= '0;
        syy_r <= '0;
        sxy_r <= '0;
      end
      hcr_pkg::MS_MAC: begin
        sxx_r <= sxx_r + 24'(pxx[20:0]);
        syy_r <= syy_r + 24'(pyy[20:0]);
        sxy_r <= sxy_r + 25'(pxy);
        for (int i = 0; i < hcr_pkg::GRAD_N - 1; i++) begin
          gx_r[i] <= gx_r[i+1];
          gy_r[i] <= gy_r[i+1];
        end
      end
      hcr_pkg::MS_MUL1: begin
        p1_r <= sxx_r * syy_r;
        tr_r <= 25'(sxx_r) + 25'(syy_r);
      end
      hcr_pkg::MS_MUL2: p2_r  <= sxy_sq[47:0];
      hcr_pkg::MS_MUL3: begin
        tr2_r <= tr_r * tr_r;
        det_r <= $signed({1'b0, p1_r}) - $signed({1'b0, p2_r});
      end
      hcr_pkg::MS_MUL4: klo_r  <= k_coeff * tr2_r[31:0];
      hcr_pkg::MS_MUL5: khi_r  <= k_coeff * tr2_r[49:32];
      hcr_pkg::MS_KT:   kt_r   <= ksum[64:16];
      hcr_pkg::MS_RESP: resp_r <= resp_sat;
      default: ;
    endcase
  end

endmodule
